// ===== hw/rtl/texture_sampler_bilinear_macros.svh =====
// assertion macros shared by the texture sampler rtl
// no dependencies; define NO_ASSERTIONS to compile them away
`ifndef TEXTURE_SAMPLER_BILINEAR_MACROS_SVH
`define TEXTURE_SAMPLER_BILINEAR_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define TSB_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define TSB_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define TSB_ASSERT_IMP(label, clk, rstn, ante, cons, msg)
`define TSB_ASSERT_NEXT(label, clk, rstn, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/tsb_pkg.sv =====
// shared types, constants and helper functions of the texture sampler
// no dependencies
package tsb_pkg;

    localparam int TEXEL_DEPTH = 65536;
    localparam int ADDR_W      = $clog2(TEXEL_DEPTH);
    localparam int MAX_DIM     = 256;
    localparam int DIM_W       = $clog2(MAX_DIM + 1);
    localparam int COORD_ONE   = 65536;
    localparam int HALF_TEXEL  = 32768;
    localparam longint ROUND_HALF = 64'h0000_0000_8000_0000;

    // register indexes (byte address divided by four)
    localparam logic [2:0] REG_EDGE_MODE       = 3'd0;
    localparam logic [2:0] REG_INTERP_MODE     = 3'd1;
    localparam logic [2:0] REG_TEX_WIDTH       = 3'd2;
    localparam logic [2:0] REG_TEX_HEIGHT      = 3'd3;
    localparam logic [2:0] REG_BYTES_PER_PIXEL = 3'd4;

    // item kinds
    localparam logic ACTION_WRITE  = 1'b0;
    localparam logic ACTION_SAMPLE = 1'b1;

    // address and filter modes
    localparam logic ADDR_WRAP      = 1'b0;
    localparam logic ADDR_CLAMP     = 1'b1;
    localparam logic FILTER_NEAREST = 1'b0;
    localparam logic FILTER_BILIN   = 1'b1;

    // corner codes: bit 0 picks x1, bit 1 picks y1
    localparam logic [1:0] CORNER_00 = 2'd0;
    localparam logic [1:0] CORNER_11 = 2'd3;

    typedef struct packed {
        logic             edge_mode;
        logic             interp_mode;
        logic [DIM_W-1:0] tex_width;
        logic [DIM_W-1:0] tex_height;
        logic [2:0]       bytes_per_pixel;
    } cfg_t;

    typedef struct packed {
        logic       wr;
        logic       capture;
        logic       mul;
        logic       fix;
        logic       rd_en;
        logic [1:0] rd_sel;
        logic       lat_en;
        logic [1:0] lat_sel;
        logic       lat_all;
        logic       horz;
        logic       vert_load;
    } cmd_t;

    // width or height as used: zero reads as one, large values saturate
    function automatic logic [DIM_W-1:0] dim_eff(input logic [DIM_W-1:0] d);
        logic [DIM_W-1:0] r;
        if (d == '0) begin
            r = DIM_W'(1);
        end else if (d > DIM_W'(MAX_DIM)) begin
            r = DIM_W'(MAX_DIM);
        end else begin
            r = d;
        end
        return r;
    endfunction

    // coordinate address mode: clamp to [0,1] or keep the fraction
    function automatic logic [16:0] coord_fix(input logic [31:0] raw, input logic clamp);
        logic [16:0] r;
        if (clamp == ADDR_CLAMP) begin
            if (raw[31]) begin
                r = '0;
            end else if ($signed(raw) > $signed(32'(COORD_ONE))) begin
                r = 17'(COORD_ONE);
            end else begin
                r = raw[16:0];
            end
        end else begin
            r = {1'b0, raw[15:0]};
        end
        return r;
    endfunction

    // integer texel position, one texel outside at most, wrapped or clamped
    function automatic logic [7:0] texel_fix(input logic signed [9:0] p,
                                             input logic [DIM_W-1:0] size,
                                             input logic clamp);
        logic signed [9:0] size_s;
        logic signed [9:0] r;
        size_s = $signed({1'b0, size});
        if (p < 0) begin
            r = (clamp == ADDR_CLAMP) ? 10'sd0 : size_s - 10'sd1;
        end else if (p >= size_s) begin
            r = (clamp == ADDR_CLAMP) ? size_s - 10'sd1 : p - size_s;
        end else begin
            r = p;
        end
        return r[7:0];
    endfunction

endpackage

// ===== hw/rtl/tsb_ctrl.sv =====
// sequencer of the texture sampler: handshakes and datapath commands
// depends on tsb_pkg and texture_sampler_bilinear_macros.svh
`include "texture_sampler_bilinear_macros.svh"

module tsb_ctrl
    import tsb_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    input  logic s_action,
    output logic m_tvalid,
    input  logic m_tready,
    input  logic interp_mode,
    output cmd_t cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_FIX  = 3'd2;
    localparam logic [2:0] ST_READ = 3'd3;
    localparam logic [2:0] ST_LAST = 3'd4;
    localparam logic [2:0] ST_HORZ = 3'd5;
    localparam logic [2:0] ST_VERT = 3'd6;

    logic [2:0] state_reg, state_next;
    logic [1:0] rd_cnt_reg, rd_cnt_next;
    logic       m_valid_reg, m_valid_next;
    logic       out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign out_free = !m_valid_reg || m_tready;

    // next state and commands
    always_comb begin
        state_next   = state_reg;
        rd_cnt_next  = rd_cnt_reg;
        m_valid_next = m_valid_reg && !m_tready;
        cmd          = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (s_action == ACTION_SAMPLE) begin
                        cmd.capture = 1'b1;
                        state_next  = ST_MUL;
                    end else begin
                        cmd.wr = 1'b1;
                    end
                end
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_FIX;
            end
            ST_FIX: begin
                cmd.fix     = 1'b1;
                rd_cnt_next = CORNER_00;
                state_next  = ST_READ;
            end
            ST_READ: begin
                // issue one corner read, latch the corner of the previous read
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = rd_cnt_reg;
                if (rd_cnt_reg != CORNER_00) begin
                    cmd.lat_en  = 1'b1;
                    cmd.lat_sel = rd_cnt_reg - 2'd1;
                end
                if (interp_mode == FILTER_NEAREST || rd_cnt_reg == CORNER_11) begin
                    state_next = ST_LAST;
                end else begin
                    rd_cnt_next = rd_cnt_reg + 2'd1;
                end
            end
            ST_LAST: begin
                cmd.lat_en  = 1'b1;
                cmd.lat_sel = rd_cnt_reg;
                cmd.lat_all = (interp_mode == FILTER_NEAREST);
                state_next  = ST_HORZ;
            end
            ST_HORZ: begin
                cmd.horz   = 1'b1;
                state_next = ST_VERT;
            end
            ST_VERT: begin
                if (out_free) begin
                    cmd.vert_load = 1'b1;
                    m_valid_next  = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            rd_cnt_reg  <= CORNER_00;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            rd_cnt_reg  <= rd_cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    `TSB_ASSERT_NEXT(a_sample_starts, aclk, aresetn,
        s_tvalid && s_tready && s_action == ACTION_SAMPLE, state_reg == ST_MUL,
        "accepted sample item did not start the sequence")
    `TSB_ASSERT_NEXT(a_write_stays_idle, aclk, aresetn,
        s_tvalid && s_tready && s_action == ACTION_WRITE, state_reg == ST_IDLE,
        "write item left the idle state")
    `TSB_ASSERT_NEXT(a_result_loaded, aclk, aresetn,
        state_reg == ST_VERT && out_free, m_valid_reg && state_reg == ST_IDLE,
        "finished sample did not reach the output register")

endmodule

// ===== hw/rtl/tsb_datapath.sv =====
// datapath of the texture sampler: texel memory, addressing, blend
// depends on tsb_pkg and texture_sampler_bilinear_macros.svh
`include "texture_sampler_bilinear_macros.svh"

module tsb_datapath
    import tsb_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  cfg_t        cfg,
    input  cmd_t        cmd,
    input  logic [15:0] texel_index,
    input  logic [31:0] texel_value,
    input  logic [31:0] u_coord,
    input  logic [31:0] v_coord,
    output logic [31:0] color
);

    logic [31:0] texel_mem [TEXEL_DEPTH];

    logic [DIM_W-1:0] w_eff, h_eff;
    logic [16:0] u_fix_reg, v_fix_reg;
    logic [24:0] pu_reg, pv_reg;
    logic [7:0]  x0_reg, x1_reg, y0_reg, y1_reg;
    logic [15:0] tx_reg, ty_reg;
    logic [31:0] rd_data_reg;
    logic [31:0] tex_reg [4];
    logic [23:0] top_reg [4];
    logic [23:0] bot_reg [4];
    logic [31:0] out_reg;

    logic signed [26:0] pos_u, pos_v;
    logic signed [9:0]  ux0, ux1, vy0, vy1;
    logic [15:0]        tx_next, ty_next;
    logic [7:0]         rd_x, rd_y;
    logic [16:0]        addr_full;
    logic [ADDR_W-1:0]  rd_addr;
    logic [31:0]        masked;
    logic [23:0]        top_next [4];
    logic [23:0]        bot_next [4];
    logic [31:0]        out_next;

    assign w_eff = dim_eff(cfg.tex_width);
    assign h_eff = dim_eff(cfg.tex_height);
    assign color = out_reg;

    // texel position split: bilinear shifts by half a texel
    always_comb begin
        pos_u = $signed({2'b00, pu_reg}) - $signed(27'(HALF_TEXEL));
        pos_v = $signed({2'b00, pv_reg}) - $signed(27'(HALF_TEXEL));
        if (cfg.interp_mode == FILTER_BILIN) begin
            ux0     = pos_u[25:16];
            vy0     = pos_v[25:16];
            ux1     = ux0 + 10'sd1;
            vy1     = vy0 + 10'sd1;
            tx_next = pos_u[15:0];
            ty_next = pos_v[15:0];
        end else begin
            ux0     = $signed({1'b0, pu_reg[24:16]});
            vy0     = $signed({1'b0, pv_reg[24:16]});
            ux1     = ux0;
            vy1     = vy0;
            tx_next = '0;
            ty_next = '0;
        end
    end

    // corner address x + y*w
    always_comb begin
        rd_x      = cmd.rd_sel[0] ? x1_reg : x0_reg;
        rd_y      = cmd.rd_sel[1] ? y1_reg : y0_reg;
        addr_full = 17'(rd_y) * 17'(w_eff) + 17'(rd_x);
        rd_addr   = addr_full[ADDR_W-1:0];
    end

    // channels at or beyond bytes_per_pixel read zero
    always_comb begin
        for (int c = 0; c < 4; c++) begin
            masked[8*c +: 8] = (3'(c) < cfg.bytes_per_pixel) ? rd_data_reg[8*c +: 8] : 8'd0;
        end
    end

    // horizontal blend, c00*2^16 + (c10 - c00)*tx, exact
    always_comb begin
        for (int c = 0; c < 4; c++) begin
            logic signed [8:0]  dx_a, dx_b;
            logic signed [25:0] prod_a, prod_b, sum_a, sum_b;
            dx_a   = $signed({1'b0, tex_reg[1][8*c +: 8]}) - $signed({1'b0, tex_reg[0][8*c +: 8]});
            dx_b   = $signed({1'b0, tex_reg[3][8*c +: 8]}) - $signed({1'b0, tex_reg[2][8*c +: 8]});
            prod_a = dx_a * $signed({1'b0, tx_reg});
            prod_b = dx_b * $signed({1'b0, tx_reg});
            sum_a  = $signed({2'b00, tex_reg[0][8*c +: 8], 16'h0000}) + prod_a;
            sum_b  = $signed({2'b00, tex_reg[2][8*c +: 8], 16'h0000}) + prod_b;
            top_next[c] = sum_a[23:0];
            bot_next[c] = sum_b[23:0];
        end
    end

    // vertical blend and round half up to a byte
    always_comb begin
        for (int c = 0; c < 4; c++) begin
            logic signed [24:0] dy;
            logic signed [41:0] prod_v, sum_v;
            logic [8:0]         bval;
            dy     = $signed({1'b0, bot_reg[c]}) - $signed({1'b0, top_reg[c]});
            prod_v = dy * $signed({1'b0, ty_reg});
            sum_v  = $signed({2'b00, top_reg[c], 16'h0000}) + prod_v
                   + $signed(42'(ROUND_HALF));
            bval   = sum_v[40:32];
            out_next[8*c +: 8] = (bval > 9'd255) ? 8'd255 : bval[7:0];
        end
    end

    // texel memory, one write or one read a cycle
    always_ff @(posedge aclk) begin
        if (cmd.wr) begin
            texel_mem[texel_index[ADDR_W-1:0]] <= texel_value;
        end
        if (cmd.rd_en) begin
            rd_data_reg <= texel_mem[rd_addr];
        end
    end

    // coordinate, product and position registers
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            u_fix_reg <= coord_fix(u_coord, cfg.edge_mode);
            v_fix_reg <= coord_fix(v_coord, cfg.edge_mode);
        end
        if (cmd.mul) begin
            pu_reg <= 25'(u_fix_reg) * 25'(w_eff);
            pv_reg <= 25'(v_fix_reg) * 25'(h_eff);
        end
        if (cmd.fix) begin
            x0_reg <= texel_fix(ux0, w_eff, cfg.edge_mode);
            x1_reg <= texel_fix(ux1, w_eff, cfg.edge_mode);
            y0_reg <= texel_fix(vy0, h_eff, cfg.edge_mode);
            y1_reg <= texel_fix(vy1, h_eff, cfg.edge_mode);
            tx_reg <= tx_next;
            ty_reg <= ty_next;
        end
    end

    // corner texels, blend stages and output register
    always_ff @(posedge aclk) begin
        if (cmd.lat_en) begin
            if (cmd.lat_all) begin
                for (int k = 0; k < 4; k++) begin
                    tex_reg[k] <= masked;
                end
            end else begin
                tex_reg[cmd.lat_sel] <= masked;
            end
        end
        if (cmd.horz) begin
            for (int c = 0; c < 4; c++) begin
                top_reg[c] <= top_next[c];
                bot_reg[c] <= bot_next[c];
            end
        end
        if (cmd.vert_load) begin
            out_reg <= out_next;
        end
    end

    `TSB_ASSERT_NEXT(a_x_in_range, aclk, aresetn, cmd.fix,
        ({1'b0, x0_reg} < $past(w_eff)) && ({1'b0, x1_reg} < $past(w_eff)),
        "horizontal texel position outside the texture")
    `TSB_ASSERT_NEXT(a_y_in_range, aclk, aresetn, cmd.fix,
        ({1'b0, y0_reg} < $past(h_eff)) && ({1'b0, y1_reg} < $past(h_eff)),
        "vertical texel position outside the texture")
    `TSB_ASSERT_NEXT(a_nearest_no_weight, aclk, aresetn,
        cmd.fix && cfg.interp_mode == FILTER_NEAREST, tx_reg == '0 && ty_reg == '0,
        "nearest sample got a nonzero blend weight")

endmodule

// ===== hw/rtl/texture_sampler_bilinear.sv =====
// top level of the texture sampler: stream ports, register file, core
// depends on tsb_pkg, tsb_ctrl and tsb_datapath
//
// Usage: the input stream carries two kinds of item, told apart by s_tuser.
// A write item (s_tuser 0) stores s_tdata's texel value at its texel index;
// it returns nothing, so writes stream at one per cycle while no sample is
// in flight. A sample item (s_tuser 1) gives u,v in signed Q15.16 and returns
// one 32-bit color on the output stream. Registers on the APB port set the
// address mode, filter mode, texture size and channel count; write them only
// while no sample is in flight.
// Sequence: the single-port texel memory is read once a cycle, one corner
// texel per read. A sample is captured, multiplied, fixed, read (four corner
// reads for bilinear, one for nearest), latched, blended across and down into
// the output register; the next item is taken once the sequencer is idle again.
// Reset: aresetn clears the sequencer and sets the registers to wrap,
// nearest, 256 x 256, four channels. The texel memory is not cleared and
// holds no defined value until written.
// Stall: a result waits in the output register while m_tready is low; the
// next item is still accepted and runs up to its blend, then waits.

module texture_sampler_bilinear
    import tsb_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    // input stream
    input  logic         s_tvalid,
    output logic         s_tready,
    // tdata from bit 0: texel_index[15:0], texel_value[31:0], u_coord[31:0], v_coord[31:0]
    input  logic [111:0] s_tdata,
    // tuser: action
    input  logic         s_tuser,
    // result stream
    output logic         m_tvalid,
    input  logic         m_tready,
    // tdata from bit 0: channel_0, channel_1, channel_2, channel_3
    output logic [31:0]  m_tdata,
    // configuration port
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    cfg_t cfg_reg, cfg_next;
    cmd_t cmd;
    logic cfg_wr;
    logic [2:0] reg_index;

    assign pready    = 1'b1;
    assign reg_index = paddr[4:2];
    assign cfg_wr    = psel && penable && pwrite && pready;

    // register writes
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr) begin
            case (reg_index)
                REG_EDGE_MODE:       cfg_next.edge_mode       = pwdata[0];
                REG_INTERP_MODE:     cfg_next.interp_mode     = pwdata[0];
                REG_TEX_WIDTH:       cfg_next.tex_width       = pwdata[DIM_W-1:0];
                REG_TEX_HEIGHT:      cfg_next.tex_height      = pwdata[DIM_W-1:0];
                REG_BYTES_PER_PIXEL: cfg_next.bytes_per_pixel = pwdata[2:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.edge_mode       <= ADDR_WRAP;
            cfg_reg.interp_mode     <= FILTER_NEAREST;
            cfg_reg.tex_width       <= DIM_W'(MAX_DIM);
            cfg_reg.tex_height      <= DIM_W'(MAX_DIM);
            cfg_reg.bytes_per_pixel <= 3'd4;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // register reads
    always_comb begin
        case (reg_index)
            REG_EDGE_MODE:       prdata = {31'd0, cfg_reg.edge_mode};
            REG_INTERP_MODE:     prdata = {31'd0, cfg_reg.interp_mode};
            REG_TEX_WIDTH:       prdata = 32'(cfg_reg.tex_width);
            REG_TEX_HEIGHT:      prdata = 32'(cfg_reg.tex_height);
            REG_BYTES_PER_PIXEL: prdata = 32'(cfg_reg.bytes_per_pixel);
            default:             prdata = '0;
        endcase
    end

    tsb_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_action    (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .interp_mode (cfg_reg.interp_mode),
        .cmd         (cmd)
    );

    tsb_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .cmd         (cmd),
        .texel_index (s_tdata[15:0]),
        .texel_value (s_tdata[47:16]),
        .u_coord     (s_tdata[79:48]),
        .v_coord     (s_tdata[111:80]),
        .color       (m_tdata)
    );

endmodule

// ===== tb/tb.sv =====
// self-checking testbench for texture_sampler_bilinear: random and directed texel writes
// and samples on the stream ports, settings changed over the APB port between phases
// depends on tsb_pkg and the texture_sampler_bilinear rtl
module tb;
    import tsb_pkg::*;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int DRAIN_CYCLES = 24;
    // index just past the register list, decodes to nothing
    localparam logic [2:0] REG_SPARE = 3'd5;

    typedef enum logic [1:0] {STALL_NONE, STALL_SOME, STALL_HEAVY} stall_t;

    // expected colors, texel copy and settings copy of the sampler
    class color_scoreboard;
        cfg_t        cfg;
        logic [31:0] texels [0:TEXEL_DEPTH-1];
        logic [31:0] pending_colors [$];
        int          mismatches;

        function new();
            cfg.edge_mode       = ADDR_WRAP;
            cfg.interp_mode     = FILTER_NEAREST;
            cfg.tex_width       = DIM_W'(MAX_DIM);
            cfg.tex_height      = DIM_W'(MAX_DIM);
            cfg.bytes_per_pixel = 3'd4;
            mismatches          = 0;
        endfunction

        function void set_reg(input logic [2:0] idx, input logic [31:0] value);
            case (idx)
                REG_EDGE_MODE:       cfg.edge_mode = value[0];
                REG_INTERP_MODE:     cfg.interp_mode = value[0];
                REG_TEX_WIDTH:       cfg.tex_width = value[DIM_W-1:0];
                REG_TEX_HEIGHT:      cfg.tex_height = value[DIM_W-1:0];
                REG_BYTES_PER_PIXEL: cfg.bytes_per_pixel = value[2:0];
                default: ;
            endcase
        endfunction

        // zero reads as one, oversize saturates
        function int eff_dim(input logic [DIM_W-1:0] d);
            if (d == '0) return 1;
            if (d > MAX_DIM) return MAX_DIM;
            return d;
        endfunction

        // coordinate to unsigned Q.16 in [0, 1]
        function longint fix_coord(input logic [31:0] raw);
            longint c;
            c = $signed(raw);
            if (cfg.edge_mode == ADDR_CLAMP) begin
                if (c < 0) return 0;
                if (c > COORD_ONE) return COORD_ONE;
                return c;
            end
            return raw[15:0];
        endfunction

        function int fix_texel(input longint p, input int size);
            if (cfg.edge_mode == ADDR_CLAMP) begin
                if (p < 0) return 0;
                if (p > size - 1) return size - 1;
                return p;
            end
            return ((p % size) + size) % size;
        endfunction

        // corner texels and 16-bit weights; nearest gives one texel, zero weights
        function void texel_grid(input logic [31:0] u, v, output int x0, x1, y0, y1,
                                 output longint fx, fy);
            int w;
            int h;
            longint au;
            longint av;
            longint px;
            longint py;
            w  = eff_dim(cfg.tex_width);
            h  = eff_dim(cfg.tex_height);
            au = fix_coord(u);
            av = fix_coord(v);
            if (cfg.interp_mode == FILTER_NEAREST) begin
                x0 = fix_texel((au * w) >>> 16, w);
                y0 = fix_texel((av * h) >>> 16, h);
                x1 = x0;
                y1 = y0;
                fx = 0;
                fy = 0;
            end else begin
                // shift by half a texel, biased by one texel to stay positive
                px = au * w - HALF_TEXEL + COORD_ONE;
                py = av * h - HALF_TEXEL + COORD_ONE;
                fx = px % COORD_ONE;
                fy = py % COORD_ONE;
                x0 = fix_texel((px >>> 16) - 1, w);
                x1 = fix_texel(px >>> 16, w);
                y0 = fix_texel((py >>> 16) - 1, h);
                y1 = fix_texel(py >>> 16, h);
            end
        endfunction

        function longint texel_byte(input int x, input int y, input int c);
            int addr;
            if (c >= cfg.bytes_per_pixel) return 0;
            addr = x + y * eff_dim(cfg.tex_width);
            return texels[addr][8*c +: 8];
        endfunction

        // exact Q.32 blend, rounded half up to a byte
        function logic [31:0] predict_color(input logic [31:0] u, v);
            int x0;
            int x1;
            int y0;
            int y1;
            longint fx;
            longint fy;
            longint top;
            longint bot;
            longint sum;
            logic [31:0] color;
            texel_grid(u, v, x0, x1, y0, y1, fx, fy);
            for (int c = 0; c < 4; c++) begin
                top = texel_byte(x0, y0, c) * (COORD_ONE - fx) + texel_byte(x1, y0, c) * fx;
                bot = texel_byte(x0, y1, c) * (COORD_ONE - fx) + texel_byte(x1, y1, c) * fx;
                sum = (top * (COORD_ONE - fy) + bot * fy + ROUND_HALF) >>> 32;
                color[8*c +: 8] = (sum > 255) ? 8'd255 : sum[7:0];
            end
            return color;
        endfunction

        // accepted input item: store a texel or queue the color it will give
        function void take_item(input logic action, input logic [111:0] data);
            if (action == ACTION_WRITE) begin
                texels[data[15:0]] = data[47:16];
            end else begin
                pending_colors.push_back(predict_color(data[79:48], data[111:80]));
            end
        endfunction

        function void check_color(input logic [31:0] got);
            logic [31:0] want;
            bit bad;
            if (pending_colors.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected color %h, none pending", got);
                return;
            end
            want = pending_colors.pop_front();
            bad  = 1'b0;
            for (int c = 0; c < 4; c++) begin
                if (got[8*c +: 8] !== want[8*c +: 8]) bad = 1'b1;
            end
            if (bad) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("color mismatch: expected ch0..3 %0d %0d %0d %0d, got %0d %0d %0d %0d",
                             want[7:0], want[15:8], want[23:16], want[31:24],
                             got[7:0], got[15:8], got[23:16], got[31:24]);
                end
            end
        endfunction
    endclass

    logic         aclk     = 1'b0;
    logic         aresetn  = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    // tdata from bit 0: texel_index[15:0], texel_value[31:0], u_coord[31:0], v_coord[31:0]
    logic [111:0] s_tdata  = '0;
    // tuser: action
    logic         s_tuser  = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    // tdata from bit 0: channel_0, channel_1, channel_2, channel_3
    logic [31:0]  m_tdata;
    logic         psel     = 1'b0;
    logic         penable  = 1'b0;
    logic         pwrite   = 1'b0;
    logic [4:0]   paddr    = '0;
    logic [31:0]  pwdata   = '0;
    logic [31:0]  prdata;
    logic         pready;

    color_scoreboard board;
    bit     loaded [0:TEXEL_DEPTH-1];
    int     burst_left  = 0;
    int     cycles      = 0;
    stall_t stall_style = STALL_NONE;
    int     stall_left  = 0;

    texture_sampler_bilinear u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // run limit
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("texture_sampler_bilinear regression: fail");
            $finish;
        end
    end

    // receiver stalls: stretches of always ready, light and heavy stalling
    always @(posedge aclk) begin
        if (stall_left == 0) begin
            stall_style <= stall_t'($urandom_range(0, 2));
            stall_left  <= $urandom_range(16, 128);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_style)
            STALL_NONE: m_tready <= 1'b1;
            STALL_SOME: m_tready <= 1'($urandom_range(0, 1));
            default:    m_tready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // monitors on both streams
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) board.take_item(s_tuser, s_tdata);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) board.check_color(m_tdata);
    end

    function automatic logic [31:0] random_texel();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // coordinates: anywhere, near the unit range, on texel edges and centers, extremes
    function automatic logic [31:0] rand_coord(input int dim);
        longint k;
        case ($urandom_range(0, 9))
            0, 1:    return $urandom;
            2, 3, 4: return 32'($urandom_range(0, 32'h40000)) - 32'h18000;
            5, 6, 7: begin
                k = $urandom_range(0, 2 * dim);
                return 32'((k * HALF_TEXEL) / dim + $urandom_range(0, 2) - 1);
            end
            default: begin
                case ($urandom_range(0, 5))
                    0:       return 32'h0000_0000;
                    1:       return 32'(COORD_ONE);
                    2:       return 32'h7FFF_FFFF;
                    3:       return 32'h8000_0000;
                    4:       return 32'hFFFF_FFFF;
                    default: return {16'($urandom), 16'h0000};
                endcase
            end
        endcase
    endfunction

    function automatic logic [8:0] pick_dim();
        case ($urandom_range(0, 9))
            0:          return 9'd1;
            1:          return 9'd256;
            2:          return 9'($urandom_range(0, 511));
            3, 4, 5, 6: return 9'($urandom_range(2, 16));
            default:    return 9'($urandom_range(17, 255));
        endcase
    endfunction

    // one item on the input stream, in bursts with gaps between them
    task automatic send_item(input logic action, input logic [15:0] idx,
                             input logic [31:0] value, input logic [31:0] u,
                             input logic [31:0] v);
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 160)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= action;
        s_tdata  <= {v, u, value, idx};
        do @(posedge aclk); while (!s_tready);
        if (action == ACTION_WRITE) loaded[idx] = 1'b1;
    endtask

    // sample, first loading any texel it reads that was never written
    task automatic sample_at(input logic [31:0] u, input logic [31:0] v);
        int xs[2];
        int ys[2];
        int w;
        int addr;
        longint fx;
        longint fy;
        board.texel_grid(u, v, xs[0], xs[1], ys[0], ys[1], fx, fy);
        w = board.eff_dim(board.cfg.tex_width);
        for (int j = 0; j < 2; j++) begin
            for (int i = 0; i < 2; i++) begin
                addr = xs[i] + ys[j] * w;
                if (!loaded[addr]) begin
                    send_item(ACTION_WRITE, addr[15:0], random_texel(), $urandom, $urandom);
                end
            end
        end
        send_item(ACTION_SAMPLE, 16'($urandom), $urandom, u, v);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        burst_left = 0;
        do @(posedge aclk); while (board.pending_colors.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        board.set_reg(idx, value);
        @(posedge aclk);
    endtask

    task automatic configure(input logic am, input logic fm, input logic [8:0] w,
                             input logic [8:0] h, input logic [2:0] bpp);
        wait_idle();
        write_reg(REG_EDGE_MODE, 32'(am));
        write_reg(REG_INTERP_MODE, 32'(fm));
        write_reg(REG_TEX_WIDTH, 32'(w));
        write_reg(REG_TEX_HEIGHT, 32'(h));
        write_reg(REG_BYTES_PER_PIXEL, 32'(bpp));
    endtask

    // mix of texel writes, in the texture or anywhere, and samples
    task automatic random_phase(input int count);
        int w;
        int h;
        int idx;
        w = board.eff_dim(board.cfg.tex_width);
        h = board.eff_dim(board.cfg.tex_height);
        repeat (count) begin
            case ($urandom_range(0, 9))
                0: send_item(ACTION_WRITE, 16'($urandom), random_texel(), $urandom, $urandom);
                1, 2: begin
                    idx = $urandom_range(0, w * h - 1);
                    send_item(ACTION_WRITE, idx[15:0], random_texel(), $urandom, $urandom);
                end
                default: sample_at(rand_coord(w), rand_coord(h));
            endcase
        end
    endtask

    initial begin
        board = new();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: wrap, nearest, 256 x 256, four channels
        send_item(ACTION_WRITE, 16'h0000, 32'h0403_0201, '1, '0);
        send_item(ACTION_WRITE, 16'hFFFF, 32'hFFFF_FFFF, '0, '1);
        send_item(ACTION_WRITE, 16'h00FF, 32'h80FF_007F, $urandom, $urandom);
        sample_at(32'h0000_0000, 32'h0000_0000);
        sample_at(32'h0000_FFFF, 32'h0000_FFFF);
        sample_at(32'h7FFF_FFFF, 32'h8000_0000);
        sample_at(32'hFFFF_FFFF, 32'h0001_0000);

        // clamp and bilinear at full size: edges, out of range, half-texel centers
        configure(ADDR_CLAMP, FILTER_BILIN, 9'd256, 9'd256, 3'd4);
        sample_at(32'h0000_0000, 32'h0000_0000);
        sample_at(32'h0001_0000, 32'h0001_0000);
        sample_at(32'h8000_0000, 32'h7FFF_FFFF);
        sample_at(32'h0000_0080, 32'h0000_0180);
        sample_at(32'h0000_8000, 32'h0000_7FFF);

        // one-texel texture, one channel
        configure(ADDR_WRAP, FILTER_BILIN, 9'd1, 9'd1, 3'd1);
        sample_at(32'h0000_8000, 32'hFFFF_8000);
        sample_at(32'h1234_5678, 32'h0000_0000);

        // zero width, oversized height, no channels, and a write to no register
        configure(ADDR_CLAMP, FILTER_NEAREST, 9'd0, 9'd300, 3'd0);
        write_reg(REG_SPARE, 32'h0000_0001);
        sample_at(32'h0000_C000, 32'h0001_0000);
        sample_at(32'hFFFF_0000, 32'h0000_4000);

        // oversized width, zero height, more channels than four
        configure(ADDR_WRAP, FILTER_BILIN, 9'd511, 9'd0, 3'd7);
        sample_at(32'h0000_0000, 32'h0000_FFFF);
        sample_at(32'h0000_7F80, 32'h8000_0001);

        // random settings, each with a stretch of 70 random items
        repeat (8) begin
            configure(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), pick_dim(),
                      pick_dim(), ($urandom_range(0, 4) == 0) ? 3'($urandom_range(0, 7))
                                                              : 3'($urandom_range(1, 4)));
            random_phase(70);
        end

        wait_idle();
        if (board.mismatches == 0 && board.pending_colors.size() == 0) begin
            $display("texture_sampler_bilinear regression: pass");
        end else begin
            $display("texture_sampler_bilinear regression: fail");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/tsb_pkg.sv
hw/rtl/tsb_ctrl.sv
hw/rtl/tsb_datapath.sv
hw/rtl/texture_sampler_bilinear.sv
tb/tb.sv
